>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the sequencer modules.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge.
`define CLSW_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that a condition never holds at a clock edge.
`define CLSW_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/core/clsw_pkg.sv
package clsw_pkg;

	// Default number of columns in one display row.
	localparam int ROW_COLUMNS_DEF = 20;

	// Depth of the operation queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam logic CFG_FOUR_BIT_MODE = 1'b0;
	localparam logic CFG_LAYOUT_20X4   = 1'b1;

	// Display constants.
	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [7:0] SET_ADDR_CMD = 8'h80;
	localparam logic [7:0] ROW1_BASE    = 8'h40;
	localparam logic [7:0] ROW2_BASE    = 8'h14;
	localparam logic [7:0] ROW3_BASE    = 8'h54;

	typedef struct packed {
		logic [7:0] char_code;
		logic [7:0] start_pos;
		logic       end_of_string;
	} char_item_t;

	typedef struct packed {
		logic [7:0] bus_value;
		logic       register_select;
		logic       last_transfer;
	} bus_xfer_t;

	typedef struct packed {
		logic four_bit_mode;
		logic layout_20x4;
	} cfg_t;

	// One classified character: an optional set-address command and the data byte.
	typedef struct packed {
		logic       set_address;
		logic [7:0] addr_cmd;
		logic [7:0] data_byte;
	} op_t;

	// Base display address of a row; rows past the fourth start at zero.
	function automatic logic [7:0] row_base(input logic [7:0] row);
		logic [7:0] base;
		case (row)
			8'd1:    base = ROW1_BASE;
			8'd2:    base = ROW2_BASE;
			8'd3:    base = ROW3_BASE;
			default: base = 8'h00;
		endcase
		return base;
	endfunction

endpackage

>>> rtl/core/char_lcd_linear_write_sequencer.sv
// Character display write sequencer, linear positions to bus transfers.
// Path: an accepted character passes the front stage register, the queue and the output
// register. Throughput: one transfer per cycle from the output register while pop is high;
// a character makes 1 to 4 transfers (command and data bytes, times two in four-bit mode),
// and a 4-entry queue decouples classification from transfer sequencing.
// Reset: queues empty, next character starts a string, four-bit mode off, 20x4 layout on.
module char_lcd_linear_write_sequencer #(
	parameter int ROW_COLUMNS = clsw_pkg::ROW_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  clsw_pkg::char_item_t  char_item,
	output logic                  empty,
	input  logic                  pop,
	output clsw_pkg::bus_xfer_t   bus_xfer,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic                  cfg_data
);
	import clsw_pkg::*;

	cfg_t cfg_q;
	logic q_wr;
	logic q_full;
	op_t  q_wr_data;
	logic q_rd;
	op_t  q_rd_data;
	logic q_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_mode <= 1'b0;
			cfg_q.layout_20x4   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FOUR_BIT_MODE: cfg_q.four_bit_mode <= cfg_data;
				CFG_LAYOUT_20X4:   cfg_q.layout_20x4   <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	clsw_front #(
		.RowColumns(ROW_COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.char_item(char_item),
		.cfg      (cfg_q),
		.op_valid (q_wr),
		.op       (q_wr_data),
		.op_full  (q_full)
	);

	clsw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr && !q_full),
		.wr_data(q_wr_data),
		.full   (q_full),
		.rd_en  (q_rd),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	clsw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.op_valid(!q_empty),
		.op      (q_rd_data),
		.op_pop  (q_rd),
		.empty   (empty),
		.pop     (pop),
		.bus_xfer(bus_xfer)
	);

endmodule

>>> rtl/core/clsw_front.sv
`include "assert_macros.svh"

module clsw_front #(
	parameter int RowColumns = clsw_pkg::ROW_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  clsw_pkg::char_item_t  char_item,
	input  clsw_pkg::cfg_t        cfg,
	output logic                  op_valid,
	output clsw_pkg::op_t         op,
	input  logic                  op_full
);
	import clsw_pkg::*;

	// Row is found by multiplying with a rounded-up reciprocal of the row width.
	// The error stays below one row for every 8-bit position.
	localparam int         RecipMul = (65536 + RowColumns - 1) / RowColumns;
	localparam logic [16:0] RecipVal = 17'(RecipMul);
	localparam logic [7:0]  RcByte   = 8'(RowColumns);

	logic        start_q;
	logic [7:0]  next_pos_q;
	logic [7:0]  pred_q;
	logic        v_s1;
	logic [7:0]  pos_s1;
	logic [7:0]  row_s1;
	logic        first_s1;
	logic [7:0]  data_s1;

	logic        accept;
	logic        s1_go;
	logic [7:0]  pos_s0;
	logic [24:0] prod_s0;
	logic [7:0]  col_s1;
	logic [7:0]  addr_s1;

	// Handshake: the stage holds while the queue is full.
	assign accept = push && !full;
	assign s1_go  = v_s1 && !op_full;
	assign full   = v_s1 && op_full;

	// Position of this character and its row estimate.
	assign pos_s0  = start_q ? char_item.start_pos : next_pos_q;
	assign prod_s0 = 25'(pos_s0) * 25'(RecipVal);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			start_q    <= 1'b1;
			next_pos_q <= 8'd0;
		end else begin
			v_s1 <= accept || (v_s1 && op_full);
			if (accept) begin
				start_q    <= char_item.end_of_string;
				next_pos_q <= pos_s0 + 8'd1;
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1   <= pos_s0;
			row_s1   <= prod_s0[23:16];
			first_s1 <= start_q;
			data_s1  <= (char_item.char_code == 8'd0) ? SPACE_CHAR : char_item.char_code;
		end
	end

	// Address from row base and column, then the set-address decision.
	assign col_s1  = pos_s1 - 8'(16'(row_s1) * 16'(RcByte));
	assign addr_s1 = cfg.layout_20x4 ? (row_base(row_s1) + col_s1) : 8'd0;

	assign op_valid       = v_s1;
	assign op.set_address = first_s1 || (addr_s1 != pred_q);
	assign op.addr_cmd    = SET_ADDR_CMD | {1'b0, addr_s1[6:0]};
	assign op.data_byte   = data_s1;

	// The display address auto-increments after each data write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= 8'd0;
		end else if (s1_go) begin
			pred_q <= addr_s1 + 8'd1;
		end
	end

	`CLSW_CHECK(a_front_hold, v_s1 && op_full |=> v_s1 && $stable(pos_s1) && $stable(first_s1), "front stage lost a held character")
	`CLSW_NEVER(a_front_col, v_s1 && (col_s1 >= RcByte), "column out of row range")

endmodule

>>> rtl/core/clsw_queue.sv
`include "assert_macros.svh"

module clsw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  clsw_pkg::op_t  wr_data,
	output logic           full,
	input  logic           rd_en,
	output clsw_pkg::op_t  rd_data,
	output logic           empty
);
	import clsw_pkg::*;

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	op_t             slots_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full    = (count_q == CntW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	`CLSW_NEVER(a_queue_over, wr_en && full, "write into a full queue")
	`CLSW_NEVER(a_queue_under, rd_en && empty, "read from an empty queue")

endmodule

>>> rtl/core/clsw_back.sv
`include "assert_macros.svh"

module clsw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clsw_pkg::cfg_t       cfg,
	input  logic                 op_valid,
	input  clsw_pkg::op_t        op,
	output logic                 op_pop,
	output logic                 empty,
	input  logic                 pop,
	output clsw_pkg::bus_xfer_t  bus_xfer
);
	import clsw_pkg::*;

	logic       out_v_q;
	bus_xfer_t  out_q;
	logic       data_phase_q;
	logic       lo_q;

	logic       eff_data;
	logic [7:0] cur_byte;
	logic [7:0] cur_value;
	logic       cur_last;
	logic       load;

	// Current transfer: command byte first if needed, then data; nibbles high then low.
	assign eff_data  = data_phase_q || !op.set_address;
	assign cur_byte  = eff_data ? op.data_byte : op.addr_cmd;
	assign cur_value = !cfg.four_bit_mode ? cur_byte :
		(lo_q ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]});
	assign cur_last  = eff_data && (!cfg.four_bit_mode || lo_q);

	// Load the output register when it is free or its beat is taken.
	assign load   = op_valid && (!out_v_q || pop);
	assign op_pop = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q      <= 1'b0;
			data_phase_q <= 1'b0;
			lo_q         <= 1'b0;
		end else begin
			out_v_q <= load || (out_v_q && !pop);
			if (load) begin
				if (cur_last) begin
					data_phase_q <= 1'b0;
					lo_q         <= 1'b0;
				end else if (cfg.four_bit_mode && !lo_q) begin
					lo_q <= 1'b1;
				end else begin
					data_phase_q <= 1'b1;
					lo_q         <= 1'b0;
				end
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.bus_value       <= cur_value;
			out_q.register_select <= eff_data;
			out_q.last_transfer   <= cur_last;
		end
	end

	assign empty    = !out_v_q;
	assign bus_xfer = out_q;

	`CLSW_CHECK(a_back_last_data, out_v_q && out_q.last_transfer |-> out_q.register_select, "final transfer is not a data transfer")
	`CLSW_NEVER(a_back_nibble, out_v_q && cfg.four_bit_mode && (out_q.bus_value[7:4] != 4'd0), "nibble transfer uses high bus bits")

endmodule

>>> tb/sv/tb_char_lcd_linear_write_sequencer.sv
module tb_char_lcd_linear_write_sequencer;
	import clsw_pkg::*;

	localparam int ROW_COLS = ROW_COLUMNS_DEF;

	// Register settings used by the directed script.
	localparam cfg_t BYTE_GRID   = '{four_bit_mode: 1'b0, layout_20x4: 1'b1};
	localparam cfg_t NIBBLE_GRID = '{four_bit_mode: 1'b1, layout_20x4: 1'b1};
	localparam cfg_t BYTE_FLAT   = '{four_bit_mode: 1'b0, layout_20x4: 1'b0};
	localparam cfg_t NIBBLE_FLAT = '{four_bit_mode: 1'b1, layout_20x4: 1'b0};

	// One directed step: optional register change, the character, and typed-in transfers.
	typedef struct {
		logic       set_cfg;
		cfg_t       cfg;
		char_item_t item;
		int         n_known;
		bus_xfer_t  known [4];
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	char_item_t char_item = '0;
	logic       empty;
	logic       pop = 1'b0;
	bus_xfer_t  bus_xfer;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic       cfg_data = 1'b0;

	// Shadow of the block: settings, position tracking and the address the display holds.
	cfg_t       cfg_shadow = BYTE_GRID;
	logic [7:0] next_pos = 8'h00;
	logic [7:0] display_addr = 8'h00;
	logic       at_line_start = 1'b1;

	bus_xfer_t   planned_xfers [$];
	bus_xfer_t   awaited_xfers [$];
	script_row_t script [$];

	int   mismatch_count = 0;
	int   stall_request = 0;
	logic sender_quiet = 1'b0;
	logic receiver_quiet = 1'b0;

	char_lcd_linear_write_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_item (char_item),
		.empty     (empty),
		.pop       (pop),
		.bus_xfer  (bus_xfer),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Queues one byte as a single beat, or as high then low nibble in four-bit mode.
	function automatic void plan_byte(logic [7:0] value, logic rs);
		bus_xfer_t x;
		x.register_select = rs;
		x.last_transfer = 1'b0;
		if (cfg_shadow.four_bit_mode) begin
			x.bus_value = {4'h0, value[7:4]};
			planned_xfers.push_back(x);
			x.bus_value = {4'h0, value[3:0]};
			planned_xfers.push_back(x);
		end else begin
			x.bus_value = value;
			planned_xfers.push_back(x);
		end
	endfunction

	// Works out the bus transfers that one character causes and advances the shadow state.
	function automatic void plan_transfers(char_item_t it);
		logic [7:0] pos;
		logic [7:0] addr;
		logic [7:0] base;
		logic [7:0] shown;
		int row;
		planned_xfers.delete();
		pos = at_line_start ? it.start_pos : next_pos;
		if (!cfg_shadow.layout_20x4) begin
			addr = 8'h00;
		end else begin
			row = int'(pos) / ROW_COLS;
			case (row)
				1: begin
					base = ROW1_BASE;
				end
				2: begin
					base = ROW2_BASE;
				end
				3: begin
					base = ROW3_BASE;
				end
				default: begin
					base = 8'h00;
				end
			endcase
			addr = base + 8'(int'(pos) % ROW_COLS);
		end
		// A new string, or a jump the display's auto-increment does not cover, needs a command.
		if (at_line_start || addr != display_addr) begin
			plan_byte(SET_ADDR_CMD | {1'b0, addr[6:0]}, 1'b0);
			display_addr = addr;
		end
		shown = (it.char_code != 8'h00) ? it.char_code : SPACE_CHAR;
		plan_byte(shown, 1'b1);
		planned_xfers[planned_xfers.size() - 1].last_transfer = 1'b1;
		display_addr = display_addr + 8'd1;
		next_pos = pos + 8'd1;
		at_line_start = it.end_of_string;
	endfunction

	// Compares one received beat with the oldest awaited transfer.
	function automatic void check_xfer(bus_xfer_t got);
		bus_xfer_t want;
		string bad;
		if (awaited_xfers.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected transfer: value=%02h rs=%0b last=%0b",
					got.bus_value, got.register_select, got.last_transfer);
		end else begin
			want = awaited_xfers.pop_front();
			bad = "";
			if (got.bus_value !== want.bus_value)
				bad = {bad, " bus_value"};
			if (got.register_select !== want.register_select)
				bad = {bad, " register_select"};
			if (got.last_transfer !== want.last_transfer)
				bad = {bad, " last_transfer"};
			if (bad != "") begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("transfer mismatch in%s: expected %02h/%0b/%0b, got %02h/%0b/%0b",
						bad, want.bus_value, want.register_select, want.last_transfer,
						got.bus_value, got.register_select, got.last_transfer);
			end
		end
	endfunction

	function automatic bus_xfer_t xf(logic [7:0] value, logic rs, logic last);
		return bus_xfer_t'({value, rs, last});
	endfunction

	function automatic void add_row(logic set_cfg, cfg_t c, logic [7:0] ch, logic [7:0] sp,
			logic eos, int n_known = 0, bus_xfer_t k0 = '0, bus_xfer_t k1 = '0,
			bus_xfer_t k2 = '0, bus_xfer_t k3 = '0);
		script_row_t r;
		r.set_cfg = set_cfg;
		r.cfg = c;
		r.item.char_code = ch;
		r.item.start_pos = sp;
		r.item.end_of_string = eos;
		r.n_known = n_known;
		r.known[0] = k0;
		r.known[1] = k1;
		r.known[2] = k2;
		r.known[3] = k3;
		script.push_back(r);
	endfunction

	// Offers one character after a random gap and plans its transfers once it is taken.
	task automatic send_item(char_item_t it);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		char_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		plan_transfers(it);
		foreach (planned_xfers[k])
			awaited_xfers.push_back(planned_xfers[k]);
	endtask

	// Stops offering and waits until every awaited transfer has come out.
	task automatic wait_drained();
		push <= 1'b0;
		while (awaited_xfers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FOUR_BIT_MODE;
		cfg_data <= c.four_bit_mode;
		@(posedge clk);
		cfg_index <= CFG_LAYOUT_20X4;
		cfg_data <= c.layout_20x4;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_shadow = c;
	endtask

	// Mostly well-formed strings, half starting near row edges, with some loose single characters.
	task automatic send_random_phase(int count);
		int sent;
		int len;
		logic [7:0] anchor;
		char_item_t it;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 85) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
				if ($urandom_range(0, 1) == 1)
					anchor = 8'($urandom);
				else
					anchor = 8'(ROW_COLS * $urandom_range(0, 13) - $urandom_range(0, 1));
				for (int k = 0; k < len && sent < count; k++) begin
					it.char_code = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
					it.start_pos = (k == 0) ? anchor : 8'($urandom);
					it.end_of_string = (k == len - 1);
					send_item(it);
					sent++;
				end
			end else begin
				it.char_code = 8'($urandom);
				it.start_pos = 8'($urandom);
				it.end_of_string = 1'($urandom);
				send_item(it);
				sent++;
			end
		end
	endtask

	// Receiving side: random pops, plus one long hold-off when asked for.
	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = receiver_quiet ? 0 : $urandom_range(0, 16);
			// A requested hold-off is added to the usual gap so pop drops only once.
			if (stall_request > 0) begin
				gap = gap + stall_request;
				stall_request = 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			check_xfer(bus_xfer);
		end
	end

	// Stimulus: directed script at reset settings and a few others, then random phases.
	initial begin : stimulus
		cfg_t phase_cfg;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first character, space for zero, byte extremes, row wrap past 255.
		add_row(1'b0, BYTE_GRID, 8'h41, 8'h00, 1'b0, 2, xf(8'h80, 0, 0), xf(8'h41, 1, 1));
		add_row(1'b0, BYTE_GRID, 8'h00, 8'hFF, 1'b0, 1, xf(8'h20, 1, 1));
		add_row(1'b0, BYTE_GRID, 8'hFF, 8'hAA, 1'b1, 1, xf(8'hFF, 1, 1));
		add_row(1'b0, BYTE_GRID, 8'h7F, 8'hFF, 1'b0, 2, xf(8'h8F, 0, 0), xf(8'h7F, 1, 1));
		add_row(1'b0, BYTE_GRID, 8'h80, 8'h55, 1'b1, 2, xf(8'h80, 0, 0), xf(8'h80, 1, 1));
		// Strings crossing each row boundary, and one running past the fourth row.
		add_row(1'b0, BYTE_GRID, 8'h01, 8'd19, 1'b0);
		add_row(1'b0, BYTE_GRID, 8'h02, 8'h00, 1'b0);
		add_row(1'b0, BYTE_GRID, 8'h03, 8'h00, 1'b1);
		add_row(1'b0, BYTE_GRID, 8'h04, 8'd39, 1'b0);
		add_row(1'b0, BYTE_GRID, 8'h05, 8'h00, 1'b1);
		add_row(1'b0, BYTE_GRID, 8'h06, 8'd59, 1'b0);
		add_row(1'b0, BYTE_GRID, 8'h07, 8'h00, 1'b1);
		add_row(1'b0, BYTE_GRID, 8'h08, 8'd79, 1'b0);
		add_row(1'b0, BYTE_GRID, 8'h09, 8'h00, 1'b1);
		// Four-bit mode splits both command and data bytes.
		add_row(1'b1, NIBBLE_GRID, 8'h00, 8'h00, 1'b1, 4, xf(8'h08, 0, 0), xf(8'h00, 0, 0),
			xf(8'h02, 1, 0), xf(8'h00, 1, 1));
		add_row(1'b0, NIBBLE_GRID, 8'hA5, 8'h67, 1'b0);
		add_row(1'b0, NIBBLE_GRID, 8'h5A, 8'h00, 1'b1);
		// Flat layout: every character needs a fresh command to address zero.
		add_row(1'b1, BYTE_FLAT, 8'h31, 8'd50, 1'b0, 2, xf(8'h80, 0, 0), xf(8'h31, 1, 1));
		add_row(1'b0, BYTE_FLAT, 8'h32, 8'h00, 1'b0, 2, xf(8'h80, 0, 0), xf(8'h32, 1, 1));
		add_row(1'b0, BYTE_FLAT, 8'h00, 8'h00, 1'b1, 2, xf(8'h80, 0, 0), xf(8'h20, 1, 1));
		add_row(1'b1, NIBBLE_FLAT, 8'hFF, 8'hFF, 1'b0);
		add_row(1'b0, NIBBLE_FLAT, 8'h10, 8'h00, 1'b1);

		foreach (script[r]) begin
			if (script[r].set_cfg) begin
				wait_drained();
				write_config(script[r].cfg);
			end
			send_item(script[r].item);
			// Rows with typed-in transfers replace what the shadow planned.
			if (script[r].n_known > 0) begin
				repeat (planned_xfers.size()) void'(awaited_xfers.pop_back());
				for (int k = 0; k < script[r].n_known; k++)
					awaited_xfers.push_back(script[r].known[k]);
			end
		end

		// The first four phases walk every setting; strings may run across phase edges.
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			phase_cfg = (ph < 4) ? cfg_t'(2'(ph)) : cfg_t'(2'($urandom));
			write_config(phase_cfg);
			sender_quiet = ($urandom_range(0, 3) == 0);
			receiver_quiet = ($urandom_range(0, 3) == 0);
			if (ph == 2) begin
				sender_quiet = 1'b1;
				stall_request = 400;
			end
			send_random_phase(60);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && awaited_xfers.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/clsw_pkg.sv
rtl/core/clsw_front.sv
rtl/core/clsw_queue.sv
rtl/core/clsw_back.sv
rtl/core/char_lcd_linear_write_sequencer.sv
tb/sv/tb_char_lcd_linear_write_sequencer.sv
